@@ hw/rtl/sst_pkg.sv @@
// shared types, codes and defaults of the sorted set table
package sst_pkg;

	localparam int DEFAULT_DEPTH     = 64;
	localparam int DEFAULT_KEY_WIDTH = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// status codes
	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_DUPLICATE = 3'd1;
	localparam logic [2:0] STAT_FULL      = 3'd2;
	localparam logic [2:0] STAT_REMOVED   = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [2:0] STAT_READ_OK   = 3'd5;
	localparam logic [2:0] STAT_BAD_INDEX = 3'd6;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] key;
		logic [5:0]         index;
	} sst_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         position;
		logic signed [31:0] entry_value;
		logic [6:0]         count;
	} sst_rsp_t;

endpackage

@@ hw/rtl/sorted_set_table_top.sv @@
// sorted set table: ordered key store in one memory with search and shift sequencer
//
//  channel   | signals             | handshake
//  ----------+---------------------+---------------------------------------------
//  request   | start, req          | taken at a rising edge with start high, busy low
//  result    | done, result        | done high for exactly one cycle per request
//  capacity  | cfg_we, cfg_data    | written at a rising edge with cfg_we high
//
// one request is worked on at a time; busy stays high until its result is out, and
//   the next request can be taken once busy is low.
// insert/remove: a binary search of midpoint reads and compares, then a check of the
//   key at the lower bound; insert then moves one key up per cycle and writes the
//   new key into the gap, remove moves one key down per cycle; the longest request
//   is a remove at the front of a full 64-entry table.
// in-range read returns the key at index; bad index or unused command: never busy.
// the shift rate is set by the memory: one read and one write per cycle.
// reset clears the count and sets capacity to the built depth; the key memory is
//   not cleared, entries at or above the count may be read but never reach a result.
// the receiver cannot stall: a result is shown once on the cycle after it is formed.
module sorted_set_table_top
	import sst_pkg::*;
#(
	parameter int DEPTH     = DEFAULT_DEPTH,
	parameter int KEY_WIDTH = DEFAULT_KEY_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sst_req_t req,
	output logic     done,
	output sst_rsp_t result,
	input  logic     cfg_we,
	input  logic [6:0] cfg_data
);

	// address width, count width and capacity register width
	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CPW = (CW > 7) ? CW : 7;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SRCH  = 3'd1;  // issue read of the search midpoint
	localparam logic [2:0] ST_CMP   = 3'd2;  // narrow the window on the read key
	localparam logic [2:0] ST_CHK   = 3'd3;  // test the key at the lower bound
	localparam logic [2:0] ST_SHUP  = 3'd4;  // move keys up to open a gap
	localparam logic [2:0] ST_INS   = 3'd5;  // write the new key into the gap
	localparam logic [2:0] ST_SHDN  = 3'd6;  // move keys down over the removed one
	localparam logic [2:0] ST_RDOUT = 3'd7;  // return the key read at index

	logic [2:0] state_q;

	// request latched at acceptance
	logic [1:0]                  cmd_q;
	logic signed [31:0]          key32_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic [5:0]                  idx_q;

	// table bookkeeping
	logic [CW-1:0]  count_q;
	logic [CPW-1:0] cap_q;

	// search window [lo, hi) and shift pointer
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid_q;
	logic [CW-1:0] j_q;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;

	// pending shift write, made in the cycle after its read
	logic          pend_s1;
	logic [AW-1:0] pwa_s1;

	// key memory: one write and one registered read per cycle
	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;
	logic [AW-1:0]        raddr;
	logic                 mem_we;
	logic [AW-1:0]        waddr;
	logic [KEY_WIDTH-1:0] wdata;

	logic        done_q;
	sst_rsp_t    result_q;

	logic [31:0] ecap;
	logic        full;
	logic        hit;
	logic        lo_in;

	// effective capacity: zero acts as one, above the depth acts as the depth
	always_comb begin
		if (cap_q == '0) begin
			ecap = 32'd1;
		end else if (32'(cap_q) > DEPTH) begin
			ecap = DEPTH;
		end else begin
			ecap = 32'(cap_q);
		end
	end

	assign full    = 32'(count_q) >= ecap;
	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
	assign mid     = mid_sum[CW:1];
	assign lo_in   = lo_q < count_q;
	assign hit     = lo_in && (rd_data_q == key_q);

	// memory port control
	always_comb begin
		raddr  = '0;
		mem_we = 1'b0;
		waddr  = pwa_s1;
		wdata  = rd_data_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = AW'(req.index);
			end
			ST_SRCH: begin
				raddr = (lo_q < hi_q) ? AW'(mid) : AW'(lo_q);
			end
			ST_SHUP: begin
				mem_we = pend_s1;
				raddr  = AW'(j_q - 1'b1);
			end
			ST_SHDN: begin
				mem_we = pend_s1;
				raddr  = AW'(j_q + 1'b1);
			end
			ST_INS: begin
				mem_we = 1'b1;
				waddr  = AW'(lo_q);
				wdata  = key_q;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CPW'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= CPW'(cfg_data);
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q   <= req.command;
			key32_q <= req.key;
			key_q   <= KEY_WIDTH'(req.key);
			idx_q   <= req.index;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			j_q      <= '0;
			pend_s1  <= 1'b0;
			pwa_s1   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						lo_q <= '0;
						hi_q <= count_q;
						priority if (req.command == CMD_INSERT || req.command == CMD_REMOVE) begin
							state_q <= ST_SRCH;
						end else if (req.command == CMD_READ) begin
							if (32'(req.index) < 32'(count_q)) begin
								state_q <= ST_RDOUT;
							end else begin
								done_q               <= 1'b1;
								result_q.status      <= STAT_BAD_INDEX;
								result_q.position    <= req.index;
								result_q.entry_value <= '0;
								result_q.count       <= 7'(count_q);
							end
						end else begin
							// unused command code
							done_q               <= 1'b1;
							result_q.status      <= STAT_BAD_INDEX;
							result_q.position    <= '0;
							result_q.entry_value <= req.key;
							result_q.count       <= 7'(count_q);
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CMP: begin
					if ($signed(rd_data_q) < key_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_SRCH;
				end
				ST_CHK: begin
					result_q.entry_value <= key32_q;
					result_q.count       <= 7'(count_q);
					if (cmd_q == CMD_INSERT) begin
						priority if (hit) begin
							done_q            <= 1'b1;
							result_q.status   <= STAT_DUPLICATE;
							result_q.position <= 6'(lo_q);
							state_q           <= ST_IDLE;
						end else if (full) begin
							done_q            <= 1'b1;
							result_q.status   <= STAT_FULL;
							result_q.position <= '0;
							state_q           <= ST_IDLE;
						end else begin
							j_q     <= count_q;
							pend_s1 <= 1'b0;
							state_q <= ST_SHUP;
						end
					end else begin
						if (hit) begin
							j_q     <= lo_q;
							pend_s1 <= 1'b0;
							state_q <= ST_SHDN;
						end else begin
							done_q            <= 1'b1;
							result_q.status   <= STAT_NOT_FOUND;
							result_q.position <= '0;
							state_q           <= ST_IDLE;
						end
					end
				end
				ST_SHUP: begin
					if (j_q > lo_q) begin
						pend_s1 <= 1'b1;
						pwa_s1  <= AW'(j_q);
						j_q     <= j_q - 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					count_q              <= count_q + 1'b1;
					done_q               <= 1'b1;
					result_q.status      <= STAT_INSERTED;
					result_q.position    <= 6'(lo_q);
					result_q.entry_value <= key32_q;
					result_q.count       <= 7'(count_q + 1'b1);
					state_q              <= ST_IDLE;
				end
				ST_SHDN: begin
					if (CW'(j_q + 1'b1) < count_q) begin
						pend_s1 <= 1'b1;
						pwa_s1  <= AW'(j_q);
						j_q     <= j_q + 1'b1;
					end else begin
						// last pending move is written this cycle
						pend_s1              <= 1'b0;
						count_q              <= count_q - 1'b1;
						done_q               <= 1'b1;
						result_q.status      <= STAT_REMOVED;
						result_q.position    <= 6'(lo_q);
						result_q.entry_value <= key32_q;
						result_q.count       <= 7'(count_q - 1'b1);
						state_q              <= ST_IDLE;
					end
				end
				ST_RDOUT: begin
					done_q               <= 1'b1;
					result_q.status      <= STAT_READ_OK;
					result_q.position    <= idx_q;
					result_q.entry_value <= 32'(rd_data_q);
					result_q.count       <= 7'(count_q);
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// table never holds more keys than built
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("count exceeds depth");

	// search window stays ordered
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("search window broken");

	// a successful insert adds exactly one key
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STAT_INSERTED) |->
			(32'(count_q) == 32'($past(count_q)) + 32'd1))
		else $error("insert count mismatch");

	// a successful remove drops exactly one key
	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STAT_REMOVED) |->
			(32'(count_q) + 32'd1 == 32'($past(count_q))))
		else $error("remove count mismatch");

	// the memory is only written while shifting or placing a key
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SHUP || state_q == ST_SHDN || state_q == ST_INS))
		else $error("memory write outside update");

endmodule

@@ test/sst_table_checker.sv @@
// checker for the sorted set table: predicts each result and compares it with the block
module sst_table_checker
	import sst_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  sst_req_t   req,
	input  logic       done,
	input  sst_rsp_t   result,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	output int         errors,
	output int         pending
);

	logic signed [31:0] table_keys [DEPTH];
	int                 key_count;
	logic [6:0]         capacity;
	sst_rsp_t           awaited_rsp [$];

	function automatic int usable_capacity();
		if (capacity == 0) return 1;
		if (capacity > DEPTH) return DEPTH;
		return capacity;
	endfunction

	// one request against the modeled table; returns the result it should give
	function automatic sst_rsp_t apply_command(sst_req_t r);
		sst_rsp_t           rsp;
		logic signed [31:0] k;
		int                 slot;
		int                 hit;
		int                 j;
		k = $signed(r.key);
		rsp = '{status: STAT_BAD_INDEX, position: '0, entry_value: r.key, count: '0};
		case (r.command)
			CMD_INSERT: begin
				slot = 0;
				while (slot < key_count && table_keys[slot] < k) slot++;
				if (slot < key_count && table_keys[slot] == k) begin
					rsp.status   = STAT_DUPLICATE;
					rsp.position = 6'(slot);
				end else if (key_count >= usable_capacity()) begin
					rsp.status = STAT_FULL;
				end else begin
					for (j = key_count; j > slot; j--) table_keys[j] = table_keys[j - 1];
					table_keys[slot] = k;
					key_count++;
					rsp.status   = STAT_INSERTED;
					rsp.position = 6'(slot);
				end
			end
			CMD_REMOVE: begin
				hit = -1;
				for (j = 0; j < key_count; j++) if (table_keys[j] == k) hit = j;
				if (hit < 0) begin
					rsp.status = STAT_NOT_FOUND;
				end else begin
					for (j = hit; j + 1 < key_count; j++) table_keys[j] = table_keys[j + 1];
					key_count--;
					rsp.status   = STAT_REMOVED;
					rsp.position = 6'(hit);
				end
			end
			CMD_READ: begin
				rsp.position = r.index;
				if (int'(r.index) < key_count) begin
					rsp.status      = STAT_READ_OK;
					rsp.entry_value = table_keys[r.index];
				end else begin
					rsp.status      = STAT_BAD_INDEX;
					rsp.entry_value = '0;
				end
			end
			default: ;
		endcase
		rsp.count = 7'(key_count);
		return rsp;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t sst mismatch: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sst_rsp_t wanted;
		if (!arst_n) begin
			key_count = 0;
			capacity  = 7'(DEPTH);
			awaited_rsp.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// results first, so a request taken on this edge cannot match them
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("result with no request waiting: %p", result));
				end else begin
					wanted = awaited_rsp.pop_front();
					if (result.status !== wanted.status)
						report_mismatch($sformatf("status %0d, want %0d",
							result.status, wanted.status));
					if (result.position !== wanted.position)
						report_mismatch($sformatf("position %0d, want %0d",
							result.position, wanted.position));
					if (result.entry_value !== wanted.entry_value)
						report_mismatch($sformatf("entry_value %0d, want %0d",
							result.entry_value, wanted.entry_value));
					if (result.count !== wanted.count)
						report_mismatch($sformatf("count %0d, want %0d",
							result.count, wanted.count));
				end
			end
			if (start && !busy) awaited_rsp.push_back(apply_command(req));
			if (cfg_we) capacity = cfg_data;
			pending = awaited_rsp.size();
		end
	end

endmodule

@@ test/sorted_set_table_top_test.sv @@
// testbench top of the sorted set table: request stimulus, capacity phases and verdict
module sorted_set_table_top_test;
	import sst_pkg::*;

	// the one command code the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         N_PHASE    = 8;
	localparam int         PHASE_LEN  = 150;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	sst_req_t   req;
	logic       done;
	sst_rsp_t   result;
	logic       cfg_we;
	logic [6:0] cfg_data;
	int         errors;
	int         pending;

	// keys sent by inserts, so removes mostly hit something held
	logic signed [31:0] seen_keys [$];

	// capacity and insert share (percent) of each random phase
	int phase_cap [N_PHASE] = '{64, 8, 0, 1, 127, 100, 20, 64};
	int phase_ins [N_PHASE] = '{85, 50, 20, 50, 80, 15, 60, 45};

	sorted_set_table_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	sst_table_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a run still going when this delay ends is reported as failed
	initial begin
		#4000000;
		$display("sorted_set_table_top verification failed");
		$finish;
	end

	// present one request at the falling edge, hold it until the block takes it and wait while the block is busy
	task automatic send(logic [1:0] cmd, logic [31:0] k, logic [5:0] idx);
		@(negedge clk);
		start       = 1'b1;
		req.command = cmd;
		req.key     = k;
		req.index   = idx;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// sender gap: start low, its length given by the argument
	task automatic pause_requests(int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending and let every awaited result come out
	task automatic wait_all_results();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// capacity is only written with the block idle
	task automatic set_capacity(logic [6:0] cap);
		wait_all_results();
		cfg_we   = 1'b1;
		cfg_data = cap;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly a narrow band around zero so keys collide, plus extremes and full range
	function automatic logic signed [31:0] rand_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0, 1: k = $urandom();
			2: k = 32'h8000_0000 + $urandom_range(0, 3);
			3: k = 32'h7fff_fffc + $urandom_range(0, 3);
			default: k = $urandom_range(0, 300) - 150;
		endcase
		return k;
	endfunction

	initial begin : stimulus
		int                 p;
		int                 n;
		int                 pick;
		logic signed [31:0] k;
		logic [5:0]         idx;

		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// empty table: read past the count, remove a missing key, unused command
		send(CMD_READ, 32'd0, 6'd0);
		send(CMD_REMOVE, 32'd5, 6'h3f);
		send(CMD_UNUSED, 32'hdead_beef, 6'h3f);

		// extremes of the key, then duplicates in the middle and at the front
		send(CMD_INSERT, 32'd0, 6'd0);
		send(CMD_INSERT, 32'h8000_0000, 6'h3f);
		send(CMD_INSERT, 32'h7fff_ffff, 6'd0);
		send(CMD_INSERT, 32'hffff_ffff, 6'd0);
		send(CMD_INSERT, 32'd1, 6'd0);
		send(CMD_INSERT, 32'd0, 6'd0);
		send(CMD_INSERT, 32'h8000_0000, 6'd0);

		// reads inside and past the count
		send(CMD_READ, 32'd0, 6'd0);
		send(CMD_READ, 32'd0, 6'd4);
		send(CMD_READ, 32'hffff_ffff, 6'd5);
		send(CMD_READ, 32'd0, 6'h3f);

		// remove the last and the first key, and a missing one
		send(CMD_REMOVE, 32'h7fff_ffff, 6'd0);
		send(CMD_REMOVE, 32'h8000_0000, 6'd0);
		send(CMD_REMOVE, 32'd7, 6'd0);
		send(CMD_INSERT, 32'h5555_5555, 6'd0);
		send(CMD_INSERT, 32'haaaa_aaaa, 6'd0);

		// capacity below the count: new keys refused, duplicates still found first
		set_capacity(7'd2);
		send(CMD_INSERT, 32'd3, 6'd0);
		send(CMD_INSERT, 32'd1, 6'd0);
		send(CMD_REMOVE, 32'hffff_ffff, 6'd0);
		send(CMD_READ, 32'd0, 6'd3);
		send(CMD_REMOVE, 32'd0, 6'd0);

		// random phases, each under its own capacity; the last one runs without gaps
		for (p = 0; p < N_PHASE; p++) begin
			set_capacity(7'(phase_cap[p]));
			for (n = 0; n < PHASE_LEN; n++) begin
				if (p != N_PHASE - 1 && n % 50 < 35 && $urandom_range(0, 3) == 0)
					pause_requests($urandom_range(1, 10));
				pick = $urandom_range(0, 99);
				idx  = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom());
				if (pick < phase_ins[p]) begin
					k = rand_key();
					seen_keys.push_back(k);
					if (seen_keys.size() > 256) void'(seen_keys.pop_front());
					send(CMD_INSERT, k, idx);
				end else if (pick < 85) begin
					if (seen_keys.size() != 0 && $urandom_range(0, 3) != 0)
						k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
					else
						k = rand_key();
					send(CMD_REMOVE, k, idx);
				end else if (pick < 98) begin
					send(CMD_READ, $urandom(), idx);
				end else begin
					send(CMD_UNUSED, $urandom(), idx);
				end
			end
		end

		// drain, then a tail longer than the slowest request to catch stray results
		wait_all_results();
		repeat (100) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("sorted_set_table_top verification clean");
		else
			$display("sorted_set_table_top verification failed");
		$finish;
	end

endmodule
